>>> sv/assert_macros.svh
// assertion macros shared by the allocator rtl
// no dependencies; include where concurrent checks are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `ASSERT_AT(label, clk, rst_n, !(cond), msg)

`endif

>>> sv/gha_pkg.sv
// types and constants of the generational handle allocator
// no dependencies; imported by the front, back and top modules
package gha_pkg;

  localparam int unsigned MAX_SLOTS   = 1024;
  localparam int unsigned GEN_BITS    = 16;
  localparam int unsigned ID_W        = $clog2(MAX_SLOTS);
  localparam int unsigned CNT_W       = ID_W + 1;
  localparam int unsigned KIND_W      = 3;
  localparam int unsigned KIND_COUNT  = 6;
  localparam int unsigned CAMERA_KIND = 4;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [3:0] {
    OP_CREATE      = 4'd0,
    OP_DESTROY     = 4'd1,
    OP_ALIVE       = 4'd2,
    OP_ADD_COMP    = 4'd3,
    OP_REMOVE_COMP = 4'd4,
    OP_HAS_COMP    = 4'd5,
    OP_SET_CAM     = 4'd6,
    OP_GET_CAM     = 4'd7,
    OP_BY_ID       = 4'd8,
    OP_CLEAR       = 4'd9
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic [3:0]          opcode;
    logic [ID_W-1:0]     entity_id;
    logic [GEN_BITS-1:0] entity_generation;
    logic [KIND_W-1:0]   component_kind;
    logic                camera_active;
  } gha_req_t;

  typedef struct packed {
    status_e               status;
    logic [ID_W-1:0]       result_id;
    logic [GEN_BITS-1:0]   result_generation;
    logic [KIND_COUNT-1:0] component_mask;
  } gha_rsp_t;

  // classified item handed from the front to the back
  typedef struct packed {
    logic [3:0]            op;
    logic [ID_W-1:0]       id;
    logic [GEN_BITS-1:0]   gen;
    logic [KIND_COUNT-1:0] kind_bit;
    logic                  cam_kind;
    logic                  cam_on;
  } gha_job_t;

  // one slot memory word
  typedef struct packed {
    logic                  alive;
    logic [KIND_COUNT-1:0] pres;
    logic [GEN_BITS-1:0]   gen;
  } gha_slot_t;

endpackage

>>> sv/gha_ram.sv
// generic single write port ram with registered read
// no dependencies
module gha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/gha_front.sv
// front end: accepts request items, classifies them, queues them
// depends on gha_pkg
module gha_front import gha_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  gha_req_t in_item_i,
  output logic     job_valid_o,
  input  logic     job_ready_i,
  output gha_job_t job_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  gha_job_t         job_in;
  gha_job_t         q_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   count_q, count_d;
  logic             push, pop;

  // classify the request
  always_comb begin
    job_in.op       = in_item_i.opcode;
    job_in.id       = in_item_i.entity_id;
    job_in.gen      = in_item_i.entity_generation;
    job_in.kind_bit = (in_item_i.component_kind < KIND_W'(KIND_COUNT)) ?
                      (KIND_COUNT'(1) << in_item_i.component_kind) : '0;
    job_in.cam_kind = (in_item_i.component_kind == KIND_W'(CAMERA_KIND));
    job_in.cam_on   = in_item_i.camera_active;
  end

  assign in_ready_o  = (count_q != (PTR_W+1)'(QUEUE_DEPTH));
  assign job_valid_o = (count_q != '0);
  assign job_o       = q_mem[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = job_valid_o && job_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= job_in;
    end
  end

endmodule

>>> sv/gha_back.sv
// back end: slot and free stack memories, sequencer, output register
// depends on gha_pkg, gha_ram and assert_macros.svh
`include "assert_macros.svh"
module gha_back import gha_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     job_valid_i,
  output logic     job_ready_o,
  input  gha_job_t job_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output gha_rsp_t out_item_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_POP  = 3'b010,
    S_EXEC = 3'b100
  } state_e;

  state_e              state_q, state_d;
  gha_job_t            cur_q, cur_d;
  logic [ID_W-1:0]     rd_addr_q, rd_addr_d;
  logic [CNT_W-1:0]    fc_q, fc_d;
  logic [CNT_W-1:0]    fresh_q, fresh_d;
  logic [ID_W-1:0]     cam_id_q, cam_id_d;
  logic [GEN_BITS-1:0] cam_gen_q, cam_gen_d;
  logic                out_valid_q, out_valid_d;
  gha_rsp_t            out_q, out_d;

  logic                   slot_re, slot_we;
  logic [ID_W-1:0]        slot_raddr;
  logic [$bits(gha_slot_t)-1:0] slot_rdata;
  gha_slot_t              slot_rd, slot_eff, slot_wdata;
  logic                   stack_re, stack_we;
  logic [ID_W-1:0]        stack_raddr, stack_rdata;
  logic [CNT_W-1:0]       fc_m1;
  logic [ID_W-1:0]        issue_addr;

  logic                  alive, cam_alive, cam_match, had, out_fire;
  logic [GEN_BITS-1:0]   gen_inc, gen_next, gen_reuse;
  logic [KIND_COUNT-1:0] pres_or, pres_clr, mask_if_alive;

  gha_ram #(.WIDTH($bits(gha_slot_t)), .DEPTH(MAX_SLOTS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (rd_addr_q),
    .wdata_i (slot_wdata),
    .re_i    (slot_re),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  gha_ram #(.WIDTH(ID_W), .DEPTH(MAX_SLOTS)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stack_we),
    .waddr_i (fc_q[ID_W-1:0]),
    .wdata_i (cur_q.id),
    .re_i    (stack_re),
    .raddr_i (stack_raddr),
    .rdata_o (stack_rdata)
  );

  assign slot_rd  = slot_rdata;
  // slots at or above the fresh id counter were never written since reset or clear
  assign slot_eff = ({1'b0, rd_addr_q} < fresh_q) ? slot_rd : '0;

  assign alive     = (cur_q.id != '0) && slot_eff.alive && (slot_eff.gen == cur_q.gen);
  assign cam_alive = (cam_id_q != '0) && slot_eff.alive && (slot_eff.gen == cam_gen_q);
  assign cam_match = (cam_id_q == cur_q.id) && (cam_gen_q == cur_q.gen);
  assign had       = (slot_eff.pres & cur_q.kind_bit) != '0;
  assign gen_inc   = slot_eff.gen + 1'b1;
  assign gen_next  = (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;
  assign gen_reuse = (slot_eff.gen == '0) ? GEN_BITS'(1) : slot_eff.gen;
  assign pres_or   = slot_eff.pres | cur_q.kind_bit;
  assign pres_clr  = slot_eff.pres & ~cur_q.kind_bit;
  assign mask_if_alive = alive ? slot_eff.pres : '0;

  assign fc_m1       = fc_q - 1'b1;
  assign stack_raddr = fc_m1[ID_W-1:0];
  assign out_fire    = !out_valid_q || out_ready_i;
  assign job_ready_o = (state_q == S_IDLE);

  // slot address read for a job that needs no stack pop
  always_comb begin
    if (job_i.op == OP_CREATE) begin
      issue_addr = fresh_q[ID_W-1:0];
    end else if (job_i.op == OP_GET_CAM) begin
      issue_addr = cam_id_q;
    end else begin
      issue_addr = job_i.id;
    end
  end

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    rd_addr_d   = rd_addr_q;
    fc_d        = fc_q;
    fresh_d     = fresh_q;
    cam_id_d    = cam_id_q;
    cam_gen_d   = cam_gen_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    slot_re     = 1'b0;
    slot_raddr  = issue_addr;
    slot_we     = 1'b0;
    slot_wdata  = slot_eff;
    stack_re    = 1'b0;
    stack_we    = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          cur_d = job_i;
          if ((job_i.op == OP_CREATE) && (fc_q != '0)) begin
            stack_re = 1'b1;
            state_d  = S_POP;
          end else begin
            slot_re   = 1'b1;
            rd_addr_d = issue_addr;
            state_d   = S_EXEC;
          end
        end
      end
      S_POP: begin
        slot_re    = 1'b1;
        slot_raddr = stack_rdata;
        rd_addr_d  = stack_rdata;
        state_d    = S_EXEC;
      end
      S_EXEC: begin
        if (out_fire) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          out_d.status            = STAT_MISS;
          out_d.result_id         = '0;
          out_d.result_generation = '0;
          out_d.component_mask    = '0;
          case (cur_q.op)
            OP_CREATE: begin
              if (fc_q != '0) begin
                fc_d             = fc_m1;
                slot_we          = 1'b1;
                slot_wdata.alive = 1'b1;
                slot_wdata.gen   = gen_reuse;
                out_d.status            = STAT_OK;
                out_d.result_id         = rd_addr_q;
                out_d.result_generation = gen_reuse;
                out_d.component_mask    = slot_eff.pres;
              end else if (fresh_q < CNT_W'(MAX_SLOTS)) begin
                fresh_d          = fresh_q + 1'b1;
                slot_we          = 1'b1;
                slot_wdata.alive = 1'b1;
                slot_wdata.pres  = '0;
                slot_wdata.gen   = GEN_BITS'(1);
                out_d.status            = STAT_OK;
                out_d.result_id         = rd_addr_q;
                out_d.result_generation = GEN_BITS'(1);
              end else begin
                out_d.status = STAT_FULL;
              end
            end
            OP_DESTROY: begin
              if (alive) begin
                slot_we          = 1'b1;
                slot_wdata.alive = 1'b0;
                slot_wdata.pres  = '0;
                slot_wdata.gen   = gen_next;
                if (cam_match) begin
                  cam_id_d  = '0;
                  cam_gen_d = '0;
                end
                if (fc_q < CNT_W'(MAX_SLOTS)) begin
                  stack_we = 1'b1;
                  fc_d     = fc_q + 1'b1;
                end
                out_d.status = STAT_OK;
              end
            end
            OP_ALIVE: begin
              out_d.status         = alive ? STAT_OK : STAT_MISS;
              out_d.component_mask = mask_if_alive;
            end
            OP_ADD_COMP: begin
              out_d.component_mask = mask_if_alive;
              if (alive && (cur_q.kind_bit != '0)) begin
                slot_we         = 1'b1;
                slot_wdata.pres = pres_or;
                if (cur_q.cam_kind && cur_q.cam_on) begin
                  cam_id_d  = cur_q.id;
                  cam_gen_d = cur_q.gen;
                end
                out_d.status         = STAT_OK;
                out_d.component_mask = pres_or;
              end
            end
            OP_REMOVE_COMP: begin
              out_d.component_mask = mask_if_alive;
              if (alive && (cur_q.kind_bit != '0)) begin
                slot_we         = 1'b1;
                slot_wdata.pres = pres_clr;
                // the active camera goes even when its kind bit is absent
                if (cur_q.cam_kind && cam_match) begin
                  cam_id_d  = '0;
                  cam_gen_d = '0;
                end
                out_d.status         = had ? STAT_OK : STAT_MISS;
                out_d.component_mask = pres_clr;
              end
            end
            OP_HAS_COMP: begin
              if (alive) begin
                out_d.status         = had ? STAT_OK : STAT_MISS;
                out_d.component_mask = slot_eff.pres;
              end
            end
            OP_SET_CAM: begin
              out_d.component_mask = mask_if_alive;
              if (alive && slot_eff.pres[CAMERA_KIND]) begin
                cam_id_d     = cur_q.id;
                cam_gen_d    = cur_q.gen;
                out_d.status = STAT_OK;
              end
            end
            OP_GET_CAM: begin
              if (cam_alive) begin
                out_d.status            = STAT_OK;
                out_d.result_id         = cam_id_q;
                out_d.result_generation = cam_gen_q;
                out_d.component_mask    = slot_eff.pres;
              end
            end
            OP_BY_ID: begin
              if ((cur_q.id != '0) && slot_eff.alive) begin
                out_d.status            = STAT_OK;
                out_d.result_id         = cur_q.id;
                out_d.result_generation = slot_eff.gen;
                out_d.component_mask    = slot_eff.pres;
              end
            end
            OP_CLEAR: begin
              fc_d         = '0;
              fresh_d      = CNT_W'(1);
              cam_id_d     = '0;
              cam_gen_d    = '0;
              out_d.status = STAT_OK;
            end
            default: begin
              out_d.status = STAT_MISS;
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fc_q        <= '0;
      fresh_q     <= CNT_W'(1);
      cam_id_q    <= '0;
      cam_gen_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fc_q        <= fc_d;
      fresh_q     <= fresh_d;
      cam_id_q    <= cam_id_d;
      cam_gen_q   <= cam_gen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    rd_addr_q <= rd_addr_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `ASSERT_AT(a_fc_below_fresh, clk_i, rst_ni, fc_q < fresh_q, "free count reached fresh id")
  `ASSERT_AT(a_fresh_range, clk_i, rst_ni, (fresh_q != '0) && (fresh_q <= CNT_W'(MAX_SLOTS)), "fresh id out of range")
  `ASSERT_AT(a_write_in_exec, clk_i, rst_ni, (slot_we || stack_we) |-> (state_q == S_EXEC), "memory write outside execute")
  `ASSERT_AT(a_pop_then_slot, clk_i, rst_ni, stack_re |=> (state_q == S_POP), "stack read not followed by pop step")
  `ASSERT_AT(a_cam_cleared, clk_i, rst_ni, (cam_id_q == '0) |-> (cam_gen_q == '0), "camera generation without id")

endmodule

>>> sv/generational_handle_allocator_top.sv
// top level of the generational handle allocator
// depends on gha_pkg, gha_front, gha_back (and through it gha_ram)
//
//   channel | signals                          | payload
//   --------+----------------------------------+-----------
//   request | in_valid_i / in_ready_o          | in_item_i
//   result  | out_valid_o / out_ready_i        | out_item_o
//
// in the back end an item goes through a slot memory read, then execute and write back
// a create that reuses a freed id has a free stack read before the slot read
// the front queue holds 2 classified items, so requests keep flowing while the back works
// the result sits in an output register; the back holds in execute while it is not taken
// reset and clear need no sweep: slots at or above the fresh id counter read as all zero
module generational_handle_allocator_top import gha_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  gha_req_t in_item_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output gha_rsp_t out_item_o
);

  // classified item between front and back
  gha_job_t job;
  logic     job_valid;
  logic     job_ready;

  // pass the opcode on, decode the kind, queue the item
  gha_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  // memories, counters, active camera and result register
  gha_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

>>> tb/sv/generational_handle_allocator_top_tb.sv
// self-checking testbench for generational_handle_allocator_top
// depends on gha_pkg and the allocator rtl; keeps its own copy of the slot tables
// to predict every result, and compares results in order as they arrive
module generational_handle_allocator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gha_pkg::*;

  localparam int          CLK_PERIOD    = 8;
  localparam int          RESET_CYCLES  = 11;
  localparam int          CYCLE_LIMIT   = 500_000;
  localparam int          SETTLE_CYCLES = 32;
  localparam int          RANDOM_ITEMS  = 64;
  localparam int          GEN_STEPS     = 8;
  localparam int          MIX_SPAN      = 256;
  localparam int          MAX_REPORTS   = 50;
  localparam int          MAX_GAP       = 16;

  localparam logic [ID_W-1:0]     MAX_ID      = '1;
  localparam logic [GEN_BITS-1:0] GEN_MAX     = '1;
  localparam logic [3:0]          OP_CODE_MAX = 4'hF;

  // component kinds; the camera kind comes from the package
  localparam int KIND_TRANSFORM = 0;
  localparam int KIND_MESH      = 1;
  localparam int KIND_SCRIPT    = 5;
  localparam int KIND_MAX       = (1 << KIND_W) - 1;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  gha_req_t in_item_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  gha_rsp_t out_item_o;

  generational_handle_allocator_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // shadow copy of the allocator state
  logic [ID_W-1:0]       freed_ids  [MAX_SLOTS];
  int unsigned           freed_count;
  int unsigned           fresh_id;
  logic [GEN_BITS-1:0]   slot_gen   [MAX_SLOTS];
  logic                  slot_live  [MAX_SLOTS];
  logic [KIND_COUNT-1:0] slot_parts [MAX_SLOTS];
  logic [ID_W-1:0]       cam_slot;
  logic [GEN_BITS-1:0]   cam_gen;
  logic [ID_W-1:0]       last_new_id;
  logic [GEN_BITS-1:0]   last_new_gen;

  gha_rsp_t pending_results[$];

  int sender_idle_pct;
  int receiver_stall_pct;
  int items_sent;
  int results_checked;
  int full_results;
  int mismatches;
  int cycle_count;

  function automatic void reset_allocator_model();
    for (int i = 0; i < MAX_SLOTS; i++) begin
      slot_gen[i]   = '0;
      slot_live[i]  = 1'b0;
      slot_parts[i] = '0;
    end
    freed_count = 0;
    fresh_id    = 1;
    cam_slot    = '0;
    cam_gen     = '0;
  endfunction

  function automatic logic handle_is_live(logic [ID_W-1:0] id, logic [GEN_BITS-1:0] gen);
    return id != '0 && id < MAX_SLOTS && slot_live[id] && slot_gen[id] == gen;
  endfunction

  // applies one item to the shadow state and returns the result it must produce
  function automatic gha_rsp_t predict_allocator_result(gha_req_t req);
    gha_rsp_t              rsp;
    logic [ID_W-1:0]       id;
    logic [ID_W-1:0]       nid;
    logic [GEN_BITS-1:0]   gen;
    logic [KIND_COUNT-1:0] one_hot;
    logic [KIND_COUNT-1:0] kind_bit;
    logic                  live;
    logic                  no_slot;
    logic                  cam_match;
    id       = req.entity_id;
    gen      = req.entity_generation;
    one_hot  = KIND_COUNT'(1);
    kind_bit = (req.component_kind < KIND_COUNT) ? one_hot << req.component_kind : '0;
    live     = handle_is_live(id, gen);
    cam_match = cam_slot == id && cam_gen == gen;
    no_slot  = 1'b0;
    nid      = '0;
    rsp        = '0;
    rsp.status = STAT_MISS;
    case (req.opcode)
      OP_CREATE: begin
        if (freed_count > 0 && freed_count <= MAX_SLOTS) begin
          freed_count--;
          nid = freed_ids[freed_count];
        end else if (fresh_id < MAX_SLOTS) begin
          nid = fresh_id[ID_W-1:0];
          fresh_id++;
        end else begin
          no_slot = 1'b1;
        end
        if (no_slot || nid == '0) begin
          rsp.status = STAT_FULL;
        end else begin
          if (slot_gen[nid] == '0) slot_gen[nid] = GEN_BITS'(1);
          slot_live[nid]        = 1'b1;
          rsp.status            = STAT_OK;
          rsp.result_id         = nid;
          rsp.result_generation = slot_gen[nid];
          rsp.component_mask    = slot_parts[nid];
          last_new_id           = nid;
          last_new_gen          = slot_gen[nid];
        end
      end
      OP_DESTROY: begin
        if (live) begin
          slot_live[id]  = 1'b0;
          slot_parts[id] = '0;
          slot_gen[id]   = slot_gen[id] + 1'b1;
          // generation zero is never handed out
          if (slot_gen[id] == '0) slot_gen[id] = GEN_BITS'(1);
          if (cam_match) begin
            cam_slot = '0;
            cam_gen  = '0;
          end
          if (freed_count < MAX_SLOTS) begin
            freed_ids[freed_count] = id;
            freed_count++;
          end
          rsp.status = STAT_OK;
        end
      end
      OP_ALIVE: begin
        if (live) begin
          rsp.status         = STAT_OK;
          rsp.component_mask = slot_parts[id];
        end
      end
      OP_ADD_COMP: begin
        if (live) rsp.component_mask = slot_parts[id];
        if (live && kind_bit != '0) begin
          slot_parts[id] = slot_parts[id] | kind_bit;
          if (req.component_kind == CAMERA_KIND && req.camera_active) begin
            cam_slot = id;
            cam_gen  = gen;
          end
          rsp.status         = STAT_OK;
          rsp.component_mask = slot_parts[id];
        end
      end
      OP_REMOVE_COMP: begin
        if (live) rsp.component_mask = slot_parts[id];
        if (live && kind_bit != '0) begin
          // dropping the camera kind drops the active camera even if absent
          if (req.component_kind == CAMERA_KIND && cam_match) begin
            cam_slot = '0;
            cam_gen  = '0;
          end
          rsp.status         = ((slot_parts[id] & kind_bit) != '0) ? STAT_OK : STAT_MISS;
          slot_parts[id]     = slot_parts[id] & ~kind_bit;
          rsp.component_mask = slot_parts[id];
        end
      end
      OP_HAS_COMP: begin
        if (live) begin
          rsp.status         = ((slot_parts[id] & kind_bit) != '0) ? STAT_OK : STAT_MISS;
          rsp.component_mask = slot_parts[id];
        end
      end
      OP_SET_CAM: begin
        if (live) rsp.component_mask = slot_parts[id];
        if (live && slot_parts[id][CAMERA_KIND]) begin
          cam_slot   = id;
          cam_gen    = gen;
          rsp.status = STAT_OK;
        end
      end
      OP_GET_CAM: begin
        if (handle_is_live(cam_slot, cam_gen)) begin
          rsp.status            = STAT_OK;
          rsp.result_id         = cam_slot;
          rsp.result_generation = cam_gen;
          rsp.component_mask    = slot_parts[cam_slot];
        end
      end
      OP_BY_ID: begin
        if (id != '0 && id < MAX_SLOTS && slot_live[id]) begin
          rsp.status            = STAT_OK;
          rsp.result_id         = id;
          rsp.result_generation = slot_gen[id];
          rsp.component_mask    = slot_parts[id];
        end
      end
      OP_CLEAR: begin
        reset_allocator_model();
        rsp.status = STAT_OK;
      end
      default: ;
    endcase
    return rsp;
  endfunction

  function automatic gha_req_t make_req(logic [3:0] op, logic [ID_W-1:0] id,
                                        logic [GEN_BITS-1:0] gen, int kind, logic cam);
    gha_req_t req;
    req.opcode            = op;
    req.entity_id         = id;
    req.entity_generation = gen;
    req.component_kind    = kind[KIND_W-1:0];
    req.camera_active     = cam;
    return req;
  endfunction

  // random slot among those handed out, preferring live ones
  function automatic logic [ID_W-1:0] pick_live_slot();
    logic [ID_W-1:0] id;
    int unsigned     hi;
    hi = (fresh_id > 1) ? fresh_id - 1 : 1;
    id = ID_W'($urandom_range(hi, 1));
    for (int tries = 0; tries < 8 && !slot_live[id]; tries++)
      id = ID_W'($urandom_range(hi, 1));
    return id;
  endfunction

  // mostly well-formed operations on real handles, with stale handles and noise mixed in
  function automatic gha_req_t random_request();
    gha_req_t            req;
    logic [ID_W-1:0]     id;
    logic [GEN_BITS-1:0] gen;
    int                  kind;
    int unsigned         pick;
    id  = pick_live_slot();
    gen = slot_gen[id];
    if ($urandom_range(99) < 12)
      gen = ($urandom_range(1, 0) != 0) ? gen - 1'b1 : GEN_BITS'($urandom);
    kind = ($urandom_range(99) < 90) ? $urandom_range(KIND_COUNT - 1, 0)
                                     : $urandom_range(KIND_MAX, KIND_COUNT);
    pick = $urandom_range(99);
    if (pick < 20)      req = make_req(OP_CREATE, '0, '0, kind, 1'b0);
    else if (pick < 30) req = make_req(OP_DESTROY, id, gen, kind, 1'b0);
    else if (pick < 37) req = make_req(OP_ALIVE, id, gen, kind, 1'b0);
    else if (pick < 52) req = make_req(OP_ADD_COMP, id, gen, kind, 1'($urandom));
    else if (pick < 61) req = make_req(OP_REMOVE_COMP, id, gen, kind, 1'b0);
    else if (pick < 68) req = make_req(OP_HAS_COMP, id, gen, kind, 1'b0);
    else if (pick < 74) req = make_req(OP_SET_CAM, id, gen, kind, 1'b0);
    else if (pick < 79) req = make_req(OP_GET_CAM, '0, '0, kind, 1'b0);
    else if (pick < 86) req = make_req(OP_BY_ID, id, '0, kind, 1'b0);
    else if (pick < 87) req = make_req(OP_CLEAR, '0, '0, kind, 1'b0);
    else begin
      // noise: any opcode, any field value
      req = make_req(4'($urandom_range(OP_CODE_MAX, 0)), ID_W'($urandom),
                     GEN_BITS'($urandom), $urandom_range(KIND_MAX, 0), 1'($urandom));
    end
    return req;
  endfunction

  task automatic set_traffic(int idle_pct, int stall_pct);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
  endtask

  // offers one item, holds it until taken, then records what it must produce
  task automatic issue_request(gha_req_t req);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.insert(pending_results.size(), predict_allocator_result(req));
    items_sent++;
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // every operation at least once, with the corner cases of each
  task automatic test_directed_ops();
    logic [ID_W-1:0]     a;
    logic [ID_W-1:0]     b;
    logic [GEN_BITS-1:0] ga;
    logic [GEN_BITS-1:0] gb;
    set_traffic(0, 0);
    issue_request(make_req(OP_CREATE, '0, '0, KIND_TRANSFORM, 1'b0));
    a  = last_new_id;
    ga = last_new_gen;
    issue_request(make_req(OP_CREATE, MAX_ID, GEN_MAX, KIND_MAX, 1'b1));
    b  = last_new_id;
    gb = last_new_gen;
    // id zero and the top id never handed out both miss
    issue_request(make_req(OP_BY_ID, '0, '0, KIND_TRANSFORM, 1'b0));
    issue_request(make_req(OP_BY_ID, MAX_ID, GEN_MAX, KIND_TRANSFORM, 1'b0));
    issue_request(make_req(OP_ALIVE, a, ga, KIND_TRANSFORM, 1'b0));
    issue_request(make_req(OP_ALIVE, a, GEN_MAX, KIND_TRANSFORM, 1'b0));
    // no camera component yet, and no active camera
    issue_request(make_req(OP_SET_CAM, a, ga, KIND_TRANSFORM, 1'b0));
    issue_request(make_req(OP_GET_CAM, '0, '0, KIND_TRANSFORM, 1'b0));
    // camera flag on a non-camera kind does nothing
    issue_request(make_req(OP_ADD_COMP, a, ga, KIND_TRANSFORM, 1'b1));
    issue_request(make_req(OP_ADD_COMP, b, gb, CAMERA_KIND, 1'b0));
    issue_request(make_req(OP_ADD_COMP, a, ga, CAMERA_KIND, 1'b1));
    issue_request(make_req(OP_ADD_COMP, a, ga, KIND_MAX, 1'b0));
    issue_request(make_req(OP_HAS_COMP, a, ga, KIND_SCRIPT, 1'b0));
    issue_request(make_req(OP_HAS_COMP, a, ga, KIND_TRANSFORM, 1'b0));
    issue_request(make_req(OP_REMOVE_COMP, a, ga, KIND_SCRIPT, 1'b0));
    issue_request(make_req(OP_REMOVE_COMP, a, ga, KIND_COUNT, 1'b0));
    issue_request(make_req(OP_SET_CAM, b, gb, KIND_TRANSFORM, 1'b0));
    issue_request(make_req(OP_GET_CAM, '0, '0, KIND_TRANSFORM, 1'b0));
    // dropping the camera kind from the active camera clears it
    issue_request(make_req(OP_REMOVE_COMP, b, gb, CAMERA_KIND, 1'b0));
    issue_request(make_req(OP_SET_CAM, a, ga, KIND_TRANSFORM, 1'b0));
    // destroying the active camera clears it; the old handle is then dead
    issue_request(make_req(OP_DESTROY, a, ga, KIND_TRANSFORM, 1'b0));
    issue_request(make_req(OP_GET_CAM, '0, '0, KIND_TRANSFORM, 1'b0));
    issue_request(make_req(OP_DESTROY, a, ga, KIND_TRANSFORM, 1'b0));
    issue_request(make_req(OP_ADD_COMP, a, ga, KIND_MESH, 1'b0));
    issue_request(make_req(OP_CLEAR + 1'b1, a, ga, KIND_MESH, 1'b1));
    issue_request(make_req(OP_CODE_MAX, MAX_ID, GEN_MAX, KIND_MAX, 1'b1));
    // freed id comes back with the next generation
    issue_request(make_req(OP_CREATE, '0, '0, KIND_TRANSFORM, 1'b0));
    issue_request(make_req(OP_CLEAR, '0, '0, KIND_TRANSFORM, 1'b0));
  endtask

  // hand out every id, hit the full case, then check last-freed-first reuse
  task automatic test_allocator_full();
    int              idle_mix[4]  = '{0, 67, 0, 17};
    int              stall_mix[4] = '{0, 0, 67, 17};
    logic [ID_W-1:0] id;
    int              n;
    set_traffic(17, 17);
    issue_request(make_req(OP_CLEAR, '0, '0, KIND_TRANSFORM, 1'b0));
    n = 0;
    while (freed_count != 0 || fresh_id < MAX_SLOTS) begin
      // the fill walks through every idle and stall mix
      if (n % MIX_SPAN == 0)
        set_traffic(idle_mix[(n / MIX_SPAN) % 4], stall_mix[(n / MIX_SPAN) % 4]);
      issue_request(make_req(OP_CREATE, '0, '0, KIND_TRANSFORM, 1'b0));
      n++;
    end
    set_traffic(17, 17);
    repeat (2) issue_request(make_req(OP_CREATE, '0, '0, KIND_TRANSFORM, 1'b0));
    issue_request(make_req(OP_ADD_COMP, MAX_ID, slot_gen[MAX_ID], KIND_SCRIPT, 1'b0));
    issue_request(make_req(OP_BY_ID, MAX_ID, '0, KIND_TRANSFORM, 1'b0));
    repeat (3) begin
      id = pick_live_slot();
      while (!slot_live[id]) id = pick_live_slot();
      issue_request(make_req(OP_DESTROY, id, slot_gen[id], KIND_TRANSFORM, 1'b0));
    end
    repeat (4) issue_request(make_req(OP_CREATE, '0, '0, KIND_TRANSFORM, 1'b0));
    issue_request(make_req(OP_CLEAR, '0, '0, KIND_TRANSFORM, 1'b0));
  endtask

  // cycle one slot a few times; each round trip bumps its generation
  task automatic test_generation_bump();
    logic [ID_W-1:0]     id;
    logic [GEN_BITS-1:0] old_gen;
    set_traffic(0, 0);
    issue_request(make_req(OP_CLEAR, '0, '0, KIND_TRANSFORM, 1'b0));
    issue_request(make_req(OP_CREATE, '0, '0, KIND_TRANSFORM, 1'b0));
    id      = last_new_id;
    old_gen = slot_gen[id];
    repeat (GEN_STEPS) begin
      old_gen = slot_gen[id];
      issue_request(make_req(OP_DESTROY, id, old_gen, KIND_TRANSFORM, 1'b0));
      issue_request(make_req(OP_CREATE, '0, '0, KIND_TRANSFORM, 1'b0));
    end
    // the handle from before the last round trip is stale
    issue_request(make_req(OP_ALIVE, id, old_gen, KIND_TRANSFORM, 1'b0));
    issue_request(make_req(OP_ALIVE, id, slot_gen[id], KIND_TRANSFORM, 1'b0));
  endtask

  // random traffic under each idle and stall mix, draining between mixes
  task automatic test_random_traffic();
    int idle_mix[4]  = '{0, 67, 0, 17};
    int stall_mix[4] = '{0, 0, 67, 17};
    for (int p = 0; p < 4; p++) begin
      set_traffic(idle_mix[p], stall_mix[p]);
      repeat (RANDOM_ITEMS / 4) issue_request(random_request());
      // sender holds off until every outstanding result is back
      wait_results_drained();
    end
  endtask

  // receiver readiness
  always @(posedge clk_i) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else         out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // result checker: in order against the oldest prediction
  always @(posedge clk_i) begin
    gha_rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result status %0d id %0d gen %0d mask %b", $time,
                   out_item_o.status, out_item_o.result_id, out_item_o.result_generation,
                   out_item_o.component_mask);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (want.status == STAT_FULL) full_results++;
        if (out_item_o.status !== want.status ||
            out_item_o.result_id !== want.result_id ||
            out_item_o.result_generation !== want.result_generation ||
            out_item_o.component_mask !== want.component_mask) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch expected status %0d id %0d gen %0d mask %b",
                     $time, want.status, want.result_id, want.result_generation,
                     want.component_mask,
                     ", got status %0d id %0d gen %0d mask %b",
                     out_item_o.status, out_item_o.result_id,
                     out_item_o.result_generation, out_item_o.component_mask);
        end
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still outstanding", cycle_count,
             pending_results.size());
    $display("FAILURE");
    $finish;
  end

  initial begin
    items_sent      = 0;
    results_checked = 0;
    full_results    = 0;
    mismatches      = 0;
    reset_allocator_model();
    set_traffic(0, 0);
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_ops();
    test_allocator_full();
    test_generation_bump();
    test_random_traffic();

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("ran every operation and its corner cases, a fill to full with reuse,");
    $display("generation bumps and random traffic: %0d items, %0d results (%0d full)",
             items_sent, results_checked, full_results);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
